[hw/rtl/u8sd_pkg.sv]
`default_nettype none

package u8sd_pkg;

  localparam int CP_W   = 21;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 3;
  localparam int IDX_W  = 2;

  // Replacement register reset value (U+FFFD).
  localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

  localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP2    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP4    = 21'h010000;

  // Sequence lengths; LEN_NONE means no sequence is pending.
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

  // Results caused by one byte. Results past the second are always
  // replacements. A result flagged rep takes the replacement register at
  // the time it leaves the block.
  typedef struct packed {
    logic [LEN_W-1:0] cnt;
    logic [CP_W-1:0]  cp0;
    logic             rep0;
    logic [CP_W-1:0]  cp1;
    logic             rep1;
  } u8sd_bundle_t;

  typedef struct packed {
    logic             emit;
    logic             rep;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic [CP_W-1:0]  partial;
  } u8sd_lead_t;

  // Handles a byte that arrives with no sequence pending.
  function automatic u8sd_lead_t lead_decode(input logic [BYTE_W-1:0] b);
    u8sd_lead_t l;
    l = '0;
    if (b == '0) begin
      l.emit = 1'b0;
    end else if (!b[7]) begin
      l.emit = 1'b1;
      l.cp   = {{(CP_W-BYTE_W){1'b0}}, b};
    end else if (b[7:5] == 3'b110) begin
      l.len     = LEN_2;
      l.partial = {{(CP_W-5){1'b0}}, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      l.len     = LEN_3;
      l.partial = {{(CP_W-4){1'b0}}, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      l.len     = LEN_4;
      l.partial = {{(CP_W-3){1'b0}}, b[2:0]};
    end else begin
      l.emit = 1'b1;
      l.rep  = 1'b1;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/u8sd_byte_if.sv]
`default_nettype none

interface u8sd_byte_if;
  import u8sd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/u8sd_cp_if.sv]
`default_nettype none

interface u8sd_cp_if;
  import u8sd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_replacement;
  logic            last_of_run;

  modport source (output valid, output code_point, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/u8sd_decode.sv]
`default_nettype none

// Sequence state and the per-byte decode into a result bundle.
module u8sd_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [u8sd_pkg::BYTE_W-1:0] in_data,
  output u8sd_pkg::u8sd_bundle_t    bundle
);
  import u8sd_pkg::*;

  logic [CP_W-1:0]  partial_r, partial_nxt;
  logic [LEN_W-1:0] exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0] rcvd_r, rcvd_nxt;

  u8sd_lead_t       lead;
  logic [CP_W-1:0]  cp_full;
  logic [LEN_W-1:0] rcvd_inc;
  logic             is_cont;
  logic             overlong;
  logic             bad;

  always_comb begin
    lead     = lead_decode(in_data);
    is_cont  = (in_data[7:6] == 2'b10);
    cp_full  = {partial_r[CP_W-7:0], in_data[5:0]};
    rcvd_inc = rcvd_r + LEN_ONE;
    overlong = ((exp_len_r == LEN_2) && (cp_full < MIN_CP2)) ||
               ((exp_len_r == LEN_3) && (cp_full < MIN_CP3)) ||
               ((exp_len_r == LEN_4) && (cp_full < MIN_CP4));
    bad      = overlong || ((cp_full >= SURR_LO) && (cp_full <= SURR_HI)) ||
               (cp_full > MAX_SCALAR);

    bundle      = '0;
    partial_nxt = partial_r;
    exp_len_nxt = exp_len_r;
    rcvd_nxt    = rcvd_r;

    if (exp_len_r == LEN_NONE) begin
      bundle.cnt  = {{(LEN_W-1){1'b0}}, lead.emit};
      bundle.cp0  = lead.cp;
      bundle.rep0 = lead.rep;
      partial_nxt = lead.partial;
      exp_len_nxt = lead.len;
      rcvd_nxt    = (lead.len == LEN_NONE) ? LEN_NONE : LEN_ONE;
    end else if (is_cont) begin
      if (rcvd_inc >= exp_len_r) begin
        partial_nxt = '0;
        exp_len_nxt = LEN_NONE;
        rcvd_nxt    = LEN_NONE;
        if (bad) begin
          // One replacement for every byte of the rejected sequence.
          bundle.cnt  = exp_len_r;
          bundle.rep0 = 1'b1;
          bundle.rep1 = 1'b1;
        end else begin
          bundle.cnt = LEN_ONE;
          bundle.cp0 = cp_full;
        end
      end else begin
        partial_nxt = cp_full;
        rcvd_nxt    = rcvd_inc;
      end
    end else begin
      // Broken sequence: one replacement, then the byte starts over as a lead.
      bundle.cnt  = LEN_ONE + {{(LEN_W-1){1'b0}}, lead.emit};
      bundle.rep0 = 1'b1;
      bundle.cp1  = lead.cp;
      bundle.rep1 = lead.rep;
      partial_nxt = lead.partial;
      exp_len_nxt = lead.len;
      rcvd_nxt    = (lead.len == LEN_NONE) ? LEN_NONE : LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      exp_len_r <= LEN_NONE;
      rcvd_r    <= LEN_NONE;
    end else if (in_fire) begin
      partial_r <= partial_nxt;
      exp_len_r <= exp_len_nxt;
      rcvd_r    <= rcvd_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/u8sd_serializer.sv]
`default_nettype none

// Two-entry queue of result bundles, unrolled one result per cycle while out_cp is ready.
module u8sd_serializer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  u8sd_pkg::u8sd_bundle_t   bundle,
  input  logic [u8sd_pkg::CP_W-1:0] repl_value,
  output logic                     space,
  u8sd_cp_if.source                out_cp
);
  import u8sd_pkg::*;

  u8sd_bundle_t     q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r, fill_nxt;
  logic [IDX_W-1:0] idx_r;

  u8sd_bundle_t     head;
  logic             is_last;
  logic             pop;

  always_comb begin
    head    = q_r[rd_ptr_r];
    is_last = ({1'b0, idx_r} == (head.cnt - LEN_ONE));
    pop     = out_cp.valid && out_cp.ready && is_last;
    space   = (fill_r != 2'd2);

    out_cp.valid       = (fill_r != 2'd0);
    out_cp.last_of_run = is_last;
    case (idx_r)
      2'd0: begin
        out_cp.is_replacement = head.rep0;
        out_cp.code_point     = head.rep0 ? repl_value : head.cp0;
      end
      2'd1: begin
        out_cp.is_replacement = head.rep1;
        out_cp.code_point     = head.rep1 ? repl_value : head.cp1;
      end
      default: begin
        out_cp.is_replacement = 1'b1;
        out_cp.code_point     = repl_value;
      end
    endcase

    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
      idx_r    <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        idx_r    <= '0;
      end else if (out_cp.valid && out_cp.ready) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/utf8_stream_decoder_core.sv]
`default_nettype none

// Streaming UTF-8 decoder. Bytes enter on in_byte, one request per byte, and
// decoded code points leave on out_cp, one request per code point. Each byte
// is decoded in the cycle it is accepted: a sequence register holds the
// partial value, the expected length and the byte count, and the results the
// byte causes (zero to four) are written as one bundle into a two-entry
// result queue. The queue plays them out one per cycle while out_cp is ready,
// and the last result of each byte carries last_of_run. A byte is accepted
// whenever the queue has a free entry, so the input keeps moving while a
// result waits on the output. Throughput is one byte per cycle as long as
// each byte produces at most one result and out_cp is ready; a byte producing
// k results holds the output until all k have left, and the output port, at
// one result per cycle, is what limits the rate then. Results are registered
// in the queue before they leave. Malformed input (a stray continuation byte,
// a byte of 0xF8 or above, a broken or truncated sequence) gives one
// replacement result; an overlong, surrogate or out-of-range sequence gives
// one replacement per byte it held. A zero byte ends the text and flushes a
// pending sequence as one replacement. The replacement value comes from the
// cfg register (reset U+FFFD), is emitted exactly as written, and is read as
// results leave, so it is to be written only while the block is idle.
module utf8_stream_decoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  u8sd_byte_if.sink                   in_byte,
  u8sd_cp_if.source                   out_cp,
  input  logic                        cfg_we,
  input  logic [u8sd_pkg::CP_W-1:0]   cfg_data
);
  import u8sd_pkg::*;

  logic [CP_W-1:0] repl_r;
  logic            in_fire;
  logic            space;
  u8sd_bundle_t    bundle;

  // A byte is taken whenever the result queue has room for its bundle.
  assign in_byte.ready = space;
  assign in_fire       = in_byte.valid && space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else if (cfg_we) begin
      repl_r <= cfg_data;
    end
  end

  u8sd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_byte.text_byte),
    .bundle  (bundle)
  );

  // Bytes that cause no result (lead bytes, inner continuation bytes and a
  // zero byte with nothing pending) only update the sequence state.
  u8sd_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire && (bundle.cnt != LEN_NONE)),
    .bundle     (bundle),
    .repl_value (repl_r),
    .space      (space),
    .out_cp     (out_cp)
  );

endmodule

`default_nettype wire
